@@ rtl/egrw_pkg.sv @@
// Shared types, constants and step tables for the exposure/gain register writer.
package egrw_pkg;

	localparam int REQ_W   = 2;
	localparam int EXPO_W  = 32;
	localparam int GAIN_W  = 16;
	localparam int REG_W   = 16;
	localparam int CODE_W  = 6;
	localparam int QUO_W   = 16;
	// gain * 128 needs seven extra bits
	localparam int UNITY_SHIFT = 7;
	localparam int GDIV_W  = GAIN_W + UNITY_SHIFT;
	localparam int STEP_COUNT = 29;

	localparam logic [REQ_W-1:0] REQ_EXP  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_GAIN = 2'd1;
	localparam logic [REQ_W-1:0] REQ_BOTH = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

	localparam logic [REG_W-1:0] ADDR_INTEG   = 16'h3012;
	localparam logic [REG_W-1:0] ADDR_DIGITAL = 16'h305E;
	localparam logic [REG_W-1:0] ADDR_ANALOG  = 16'h3060;

	typedef struct packed {
		logic             valid;
		logic [REQ_W-1:0] req;
		logic [CODE_W-1:0] code;
	} egrw_ctl_t;

	function automatic logic [31:0] step_hundredths(input int i);
		logic [31:0] v;
		case (i)
			0: v = 100;   1: v = 103;   2: v = 107;   3: v = 110;
			4: v = 114;   5: v = 119;   6: v = 123;   7: v = 128;
			8: v = 133;   9: v = 139;   10: v = 145;  11: v = 152;
			12: v = 160;  13: v = 168;  14: v = 178;  15: v = 188;
			16: v = 200;  17: v = 213;  18: v = 229;  19: v = 246;
			20: v = 267;  21: v = 291;  22: v = 320;  23: v = 356;
			24: v = 400;  25: v = 457;  26: v = 533;  27: v = 640;
			default: v = 800;
		endcase
		return v;
	endfunction

	function automatic logic [CODE_W-1:0] step_code(input int i);
		logic [CODE_W-1:0] c;
		case (i)
			0: c = 6'h00;   1: c = 6'h01;   2: c = 6'h02;   3: c = 6'h03;
			4: c = 6'h04;   5: c = 6'h05;   6: c = 6'h06;   7: c = 6'h07;
			8: c = 6'h08;   9: c = 6'h09;   10: c = 6'h0a;  11: c = 6'h0b;
			12: c = 6'h0c;  13: c = 6'h0d;  14: c = 6'h0e;  15: c = 6'h0f;
			16: c = 6'h10;  17: c = 6'h12;  18: c = 6'h14;  19: c = 6'h16;
			20: c = 6'h18;  21: c = 6'h1a;  22: c = 6'h1c;  23: c = 6'h1e;
			24: c = 6'h20;  25: c = 6'h24;  26: c = 6'h28;  27: c = 6'h2c;
			default: c = 6'h30;
		endcase
		return c;
	endfunction

	// step in fixed point, halves rounded up
	function automatic logic [31:0] step_fixed(input int i, input int frac);
		return ((step_hundredths(i) << frac) + 32'd50) / 32'd100;
	endfunction

endpackage

@@ rtl/egrw_if.sv @@
// Request and register-write channel interfaces.
interface egrw_req_if;
	import egrw_pkg::*;
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [EXPO_W-1:0] exposure;
	logic [GAIN_W-1:0] gain_q8;

	modport source (output valid, output req_type, output exposure, output gain_q8,
		input ready);
	modport sink (input valid, input req_type, input exposure, input gain_q8,
		output ready);
endinterface

interface egrw_wr_if;
	import egrw_pkg::*;
	logic             valid;
	logic             ready;
	logic [REG_W-1:0] reg_addr;
	logic [REG_W-1:0] reg_data;
	logic             last;

	modport source (output valid, output reg_addr, output reg_data, output last,
		input ready);
	modport sink (input valid, input reg_addr, input reg_data, input last,
		output ready);
endinterface

@@ rtl/exposure_gain_register_writer.sv @@
// Top level: request channel, APB register port and register-write channel.
//
// Each item on cmd (req_type, exposure, gain_q8) becomes one to three items on
// wr: 0x3012 = exposure / exposure_min (saturated), then 0x305E (digital gain)
// and 0x3060 (analog step code in both bytes); last marks the final write.
// req_type 3 produces nothing. The user must write exposure_min over the APB
// port at byte address 0 only while the block is idle; the block does not
// enforce this. Reset sets it to 1. A request passes an input stage, a
// step-select stage, a divide setup stage and 16 divide stages (one quotient
// bit each, both divisions in parallel) before it reaches the output buffer;
// the writes of one request then go out one per cycle while wr is ready.
// Throughput is set by the output buffer: one write per cycle while wr is ready,
// and a new request loads as the last write is taken. While the buffer is busy
// and a request waits at the end of the pipeline, the whole pipeline holds
// (bubbles included) and cmd.ready drops; nothing is lost or repeated. When wr
// stalls the same hold applies. Reset clears all valid bits and the sequencer.
module exposure_gain_register_writer import egrw_pkg::*; #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	egrw_req_if.sink    cmd,
	egrw_wr_if.source   wr
);

	localparam int STEP_W = GAIN_FRAC_BITS + 4;

	logic [EXPO_W-1:0] exposure_min_q;
	logic              en;
	egrw_ctl_t         ctl_s2, ctl_pipe;
	logic [EXPO_W-1:0] expo_s2;
	logic [GDIV_W-1:0] gdiv_s2;
	logic [STEP_W-1:0] step_s2;
	logic [REG_W-1:0]  integ, dig;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? exposure_min_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exposure_min_q <= 32'd1;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			exposure_min_q <= pwdata;
		end
	end

	assign cmd.ready = en;

	egrw_front #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.STEP_W         (STEP_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (cmd.valid),
		.in_req   (cmd.req_type),
		.in_expo  (cmd.exposure),
		.in_gain  (cmd.gain_q8),
		.ctl_s2   (ctl_s2),
		.expo_s2  (expo_s2),
		.gdiv_s2  (gdiv_s2),
		.step_s2  (step_s2)
	);

	egrw_div_pipe #(
		.STEP_W (STEP_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_in    (ctl_s2),
		.expo_in   (expo_s2),
		.emin      (exposure_min_q),
		.gdiv_in   (gdiv_s2),
		.step_in   (step_s2),
		.ctl_out   (ctl_pipe),
		.integ_out (integ),
		.dig_out   (dig)
	);

	egrw_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_pipe),
		.integ_in (integ),
		.dig_in   (dig),
		.en       (en),
		.wr       (wr)
	);

endmodule

@@ rtl/egrw_front.sv @@
// Input register stage and analog step selection.
module egrw_front import egrw_pkg::*; #(
	parameter int GAIN_FRAC_BITS = 8,
	parameter int STEP_W = GAIN_FRAC_BITS + 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [REQ_W-1:0]  in_req,
	input  logic [EXPO_W-1:0] in_expo,
	input  logic [GAIN_W-1:0] in_gain,
	output egrw_ctl_t         ctl_s2,
	output logic [EXPO_W-1:0] expo_s2,
	output logic [GDIV_W-1:0] gdiv_s2,
	output logic [STEP_W-1:0] step_s2
);

	logic              valid_s1;
	logic [REQ_W-1:0]  req_s1;
	logic [EXPO_W-1:0] expo_s1;
	logic [GAIN_W-1:0] gain_s1;

	logic [STEP_W-1:0] sel_step;
	logic [CODE_W-1:0] sel_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s2   <= '0;
		end else if (en) begin
			valid_s1 <= in_valid;
			ctl_s2   <= '{valid: valid_s1, req: req_s1, code: sel_code};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1  <= in_req;
			expo_s1 <= in_expo;
			gain_s1 <= in_gain;
			expo_s2 <= expo_s1;
			gdiv_s2 <= {gain_s1, {UNITY_SHIFT{1'b0}}};
			step_s2 <= sel_step;
		end
	end

	// steps rise monotonically, so the last one passed is the largest
	always_comb begin
		sel_step = STEP_W'(step_fixed(0, GAIN_FRAC_BITS));
		sel_code = step_code(0);
		for (int i = 1; i < STEP_COUNT; i++) begin
			if (step_fixed(i, GAIN_FRAC_BITS) <= 32'(gain_s1)) begin
				sel_step = STEP_W'(step_fixed(i, GAIN_FRAC_BITS));
				sel_code = step_code(i);
			end
		end
	end

endmodule

@@ rtl/egrw_div_pipe.sv @@
// Two-lane restoring divide pipeline, one quotient bit per stage, 16-bit saturation.
module egrw_div_pipe import egrw_pkg::*; #(
	parameter int STEP_W = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  egrw_ctl_t         ctl_in,
	input  logic [EXPO_W-1:0] expo_in,
	input  logic [EXPO_W-1:0] emin,
	input  logic [GDIV_W-1:0] gdiv_in,
	input  logic [STEP_W-1:0] step_in,
	output egrw_ctl_t         ctl_out,
	output logic [REG_W-1:0]  integ_out,
	output logic [REG_W-1:0]  dig_out
);

	localparam int GHI_W = GDIV_W - QUO_W;

	egrw_ctl_t         ctl_s  [0:QUO_W];
	logic [EXPO_W-1:0] erem_s [0:QUO_W];
	logic [QUO_W-1:0]  elo_s  [0:QUO_W];
	logic [QUO_W-1:0]  equo_s [0:QUO_W];
	logic              eovf_s [0:QUO_W];
	logic [STEP_W-1:0] grem_s [0:QUO_W];
	logic [QUO_W-1:0]  glo_s  [0:QUO_W];
	logic [QUO_W-1:0]  gquo_s [0:QUO_W];
	logic              govf_s [0:QUO_W];
	logic [STEP_W-1:0] gdv_s  [0:QUO_W];

	logic [EXPO_W-1:0] ehi;
	logic [STEP_W-1:0] ghi;

	// a quotient of 2^16 or more shows as high dividend bits >= divisor
	assign ehi = {{(EXPO_W-QUO_W){1'b0}}, expo_in[EXPO_W-1:QUO_W]};
	assign ghi = {{(STEP_W-GHI_W){1'b0}}, gdiv_in[GDIV_W-1:QUO_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			erem_s[0] <= ehi;
			elo_s[0]  <= expo_in[QUO_W-1:0];
			equo_s[0] <= '0;
			eovf_s[0] <= ehi >= emin;
			grem_s[0] <= ghi;
			glo_s[0]  <= gdiv_in[QUO_W-1:0];
			gquo_s[0] <= '0;
			govf_s[0] <= ghi >= step_in;
			gdv_s[0]  <= step_in;
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_bit
		logic [EXPO_W:0] et, ediff;
		logic [STEP_W:0] gt, gdiff;
		logic            ege, gge;

		assign et    = {erem_s[k-1], elo_s[k-1][QUO_W-1]};
		assign ege   = et >= {1'b0, emin};
		assign ediff = et - {1'b0, emin};
		assign gt    = {grem_s[k-1], glo_s[k-1][QUO_W-1]};
		assign gge   = gt >= {1'b0, gdv_s[k-1]};
		assign gdiff = gt - {1'b0, gdv_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				erem_s[k] <= ege ? ediff[EXPO_W-1:0] : et[EXPO_W-1:0];
				elo_s[k]  <= {elo_s[k-1][QUO_W-2:0], 1'b0};
				equo_s[k] <= {equo_s[k-1][QUO_W-2:0], ege};
				eovf_s[k] <= eovf_s[k-1];
				grem_s[k] <= gge ? gdiff[STEP_W-1:0] : gt[STEP_W-1:0];
				glo_s[k]  <= {glo_s[k-1][QUO_W-2:0], 1'b0};
				gquo_s[k] <= {gquo_s[k-1][QUO_W-2:0], gge};
				govf_s[k] <= govf_s[k-1];
				gdv_s[k]  <= gdv_s[k-1];
			end
		end
	end

	assign ctl_out   = ctl_s[QUO_W];
	assign integ_out = eovf_s[QUO_W] ? '1 : equo_s[QUO_W];
	assign dig_out   = govf_s[QUO_W] ? '1 : gquo_s[QUO_W];

endmodule

@@ rtl/egrw_out.sv @@
// Result buffer that issues the register writes of one item and gates the pipeline.
module egrw_out import egrw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  egrw_ctl_t        ctl_in,
	input  logic [REG_W-1:0] integ_in,
	input  logic [REG_W-1:0] dig_in,
	output logic             en,
	egrw_wr_if.source        wr
);

	localparam logic [1:0] PH_INTEG = 2'd0;
	localparam logic [1:0] PH_DIG   = 2'd1;
	localparam logic [1:0] PH_ANA   = 2'd2;

	logic              valid_q;
	logic [1:0]        phase_q;
	logic [REQ_W-1:0]  req_q;
	logic [REG_W-1:0]  integ_q;
	logic [REG_W-1:0]  dig_q;
	logic [CODE_W-1:0] code_q;
	logic              take, load;

	assign take = !valid_q || (wr.ready && wr.last);
	assign en   = take || !ctl_in.valid;
	assign load = take && ctl_in.valid && (ctl_in.req != REQ_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= PH_INTEG;
			req_q   <= REQ_EXP;
		end else if (load) begin
			valid_q <= 1'b1;
			phase_q <= (ctl_in.req == REQ_GAIN) ? PH_DIG : PH_INTEG;
			req_q   <= ctl_in.req;
		end else if (valid_q && wr.ready) begin
			if (wr.last) begin
				valid_q <= 1'b0;
			end else begin
				phase_q <= (phase_q == PH_INTEG) ? PH_DIG : PH_ANA;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			integ_q <= integ_in;
			dig_q   <= dig_in;
			code_q  <= ctl_in.code;
		end
	end

	always_comb begin
		wr.valid = valid_q;
		unique case (phase_q)
			PH_INTEG: begin
				wr.reg_addr = ADDR_INTEG;
				wr.reg_data = integ_q;
				wr.last     = (req_q == REQ_EXP);
			end
			PH_DIG: begin
				wr.reg_addr = ADDR_DIGITAL;
				wr.reg_data = dig_q;
				wr.last     = 1'b0;
			end
			PH_ANA: begin
				wr.reg_addr = ADDR_ANALOG;
				wr.reg_data = {2'b00, code_q, 2'b00, code_q};
				wr.last     = 1'b1;
			end
			default: begin
				wr.reg_addr = ADDR_ANALOG;
				wr.reg_data = {2'b00, code_q, 2'b00, code_q};
				wr.last     = 1'b1;
			end
		endcase
	end

	a_exp_only_integ: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && req_q == REQ_EXP |-> phase_q == PH_INTEG)
		else $error("exposure-only item left the integration write");
	a_integ_needs_exp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && phase_q == PH_INTEG |-> req_q != REQ_GAIN)
		else $error("integration write issued for a gain-only item");
	a_dig_then_ana: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && phase_q == PH_DIG && wr.ready |=> valid_q && phase_q == PH_ANA)
		else $error("analog write did not follow digital write");
	a_no_unused_req: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> req_q != REQ_NONE)
		else $error("unused request type reached the output");

endmodule
